// File: rtl/raqc_pkg.sv
// Shared constants, register indexes, action codes and types of the RTT quality controller.
package raqc_pkg;

   localparam int RTT_W      = 16;
   localparam int Q_W        = 7;
   localparam int ACT_W      = 2;
   localparam int HOLD_W     = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int RSP_DATA_W = 32;
   localparam int WINDOW_DEF = 10;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_STEP_DOWN    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_UP      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_QUALITY_MAX  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_QUALITY_MIN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD_SAMPLES = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RTT_LOW      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_RTT_HIGH     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_INIT_QUALITY = 3'd7;

   // Reset values of the registers
   localparam logic [Q_W-1:0]    RST_STEP_DOWN    = 7'd5;
   localparam logic [Q_W-1:0]    RST_STEP_UP      = 7'd5;
   localparam logic [Q_W-1:0]    RST_QUALITY_MAX  = 7'd80;
   localparam logic [Q_W-1:0]    RST_QUALITY_MIN  = 7'd5;
   localparam logic [HOLD_W-1:0] RST_HOLD_SAMPLES = 8'd5;
   localparam logic [RTT_W-1:0]  RST_RTT_LOW      = 16'd10;
   localparam logic [RTT_W-1:0]  RST_RTT_HIGH     = 16'd100;
   localparam logic [Q_W-1:0]    RST_INIT_QUALITY = 7'd50;

   // Action codes of a result
   localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
   localparam logic [ACT_W-1:0] ACT_DOWN = 2'd1;
   localparam logic [ACT_W-1:0] ACT_UP   = 2'd2;

   localparam logic [HOLD_W-1:0] HOLD_SAT = 8'd255;

   typedef struct packed {
      logic [Q_W-1:0]    step_down;
      logic [Q_W-1:0]    step_up;
      logic [Q_W-1:0]    quality_max;
      logic [Q_W-1:0]    quality_min;
      logic [HOLD_W-1:0] hold_samples;
      logic [RTT_W-1:0]  rtt_low;
      logic [RTT_W-1:0]  rtt_high;
   } cfg_type;

endpackage

// File: rtl/raqc_front.sv
// Front end: accepts samples, keeps the window sum and decides the quality step.
module raqc_front import raqc_pkg::*; #(
   parameter int WINDOW = WINDOW_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                quality_load,
   input  logic [Q_W-1:0]      quality_value,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [RTT_W-1:0]    req_rtt_ms,
   output logic                q_push,
   output logic [RTT_W+2*$clog2(WINDOW+1)+Q_W+ACT_W-1:0] q_data,
   input  logic                q_full
);

   localparam int CNT_W   = $clog2(WINDOW + 1);
   localparam int SUM_W   = RTT_W + CNT_W;
   localparam int PTR_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_SUM  = 2'd1;
   localparam logic [1:0] F_MUL  = 2'd2;
   localparam logic [1:0] F_DEC  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [RTT_W-1:0] sample_ff, sample_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [SUM_W-1:0] hi_ff, hi_in;
   logic [SUM_W-1:0] lo_ff, lo_in;
   logic [HOLD_W-1:0] hold_ff, hold_in;
   logic [Q_W-1:0]   cur_ff, cur_in;
   logic [ACT_W-1:0] act;
   logic             ring_we;
   logic [RTT_W-1:0] ring_mem [WINDOW];
   logic [RTT_W-1:0] ring_rd_ff;
   logic             full;
   logic             armed;
   logic             dn_ok;
   logic             up_ok;

   assign full       = (fill_ff == CNT_W'(WINDOW));
   assign req_tready = (state_ff == F_IDLE);
   assign armed      = (hold_ff >= cfg.hold_samples);
   assign dn_ok      = ({1'b0, cur_ff} >= ({1'b0, cfg.quality_min} + {1'b0, cfg.step_down}));
   assign up_ok      = (({1'b0, cur_ff} + {1'b0, cfg.step_up}) <= {1'b0, cfg.quality_max});
   assign q_data     = {act, cur_in, fill_ff, sum_ff};

   always_comb begin
      state_in  = state_ff;
      sample_in = sample_ff;
      ptr_in    = ptr_ff;
      fill_in   = fill_ff;
      sum_in    = sum_ff;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      hold_in   = hold_ff;
      cur_in    = cur_ff;
      ring_we   = 1'b0;
      q_push    = 1'b0;
      act       = ACT_NONE;
      unique case (state_ff)
         F_IDLE: begin
            if (req_tvalid) begin
               sample_in = req_rtt_ms;
               state_in  = F_SUM;
            end
         end
         F_SUM: begin
            // drop the oldest sample once the window is full
            sum_in  = sum_ff + SUM_W'(sample_ff) - (full ? SUM_W'(ring_rd_ff) : '0);
            fill_in = full ? fill_ff : fill_ff + 1'b1;
            ptr_in  = (ptr_ff == PTR_W'(WINDOW - 1)) ? '0 : ptr_ff + 1'b1;
            ring_we = 1'b1;
            state_in = F_MUL;
         end
         F_MUL: begin
            hi_in    = SUM_W'(cfg.rtt_high) * SUM_W'(fill_ff);
            lo_in    = SUM_W'(cfg.rtt_low) * SUM_W'(fill_ff);
            state_in = F_DEC;
         end
         F_DEC: begin
            if (!q_full) begin
               priority if (armed && (sum_ff > hi_ff)) begin
                  if (dn_ok) begin
                     cur_in = cur_ff - cfg.step_down;
                  end
                  hold_in = HOLD_W'(1);
               end else if (armed && (sum_ff < lo_ff)) begin
                  if (up_ok) begin
                     cur_in = cur_ff + cfg.step_up;
                  end
                  hold_in = HOLD_W'(1);
               end else begin
                  hold_in = (hold_ff == HOLD_SAT) ? hold_ff : hold_ff + 1'b1;
               end
               if (cur_in < cur_ff) begin
                  act = ACT_DOWN;
               end else if (cur_in > cur_ff) begin
                  act = ACT_UP;
               end
               q_push   = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
      if (quality_load) begin
         cur_in = quality_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         ptr_ff   <= '0;
         fill_ff  <= '0;
         sum_ff   <= '0;
         hold_ff  <= '0;
         cur_ff   <= RST_INIT_QUALITY;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         fill_ff  <= fill_in;
         sum_ff   <= sum_in;
         hold_ff  <= hold_in;
         cur_ff   <= cur_in;
      end
      sample_ff <= sample_in;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ptr_ff] <= sample_ff;
      end
      ring_rd_ff <= ring_mem[ptr_ff];
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(WINDOW))
      else $error("fill count beyond window");

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= PTR_W'(WINDOW - 1))
      else $error("ring pointer beyond window");

   a_down_lowers: assert property (@(posedge clock) disable iff (reset)
      (q_push && (act == ACT_DOWN)) |=> (cur_ff < $past(cur_ff)))
      else $error("decrease reported but quality not lowered");

endmodule

// File: rtl/raqc_queue.sv
// Two-entry queue between the front end and the divider back end.
module raqc_queue import raqc_pkg::*; #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int DEPTH = 2;

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (cnt_ff == 2'(DEPTH));
   assign empty    = (cnt_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/raqc_back.sv
// Back end: serial divider for the window average and the result register.
module raqc_back import raqc_pkg::*; #(
   parameter int WINDOW = WINDOW_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   output logic              q_pop,
   input  logic [RTT_W+2*$clog2(WINDOW+1)+Q_W+ACT_W-1:0] q_data,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RTT_W-1:0]  rsp_mean_rtt,
   output logic [Q_W-1:0]    rsp_quality,
   output logic [ACT_W-1:0]  rsp_action
);

   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int SUM_W  = RTT_W + CNT_W;
   localparam int STEP_W = $clog2(SUM_W);

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_RUN  = 2'd1;
   localparam logic [1:0] B_DONE = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [SUM_W-1:0]  quot_ff, quot_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  div_ff, div_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [Q_W-1:0]    qual_ff, qual_in;
   logic [ACT_W-1:0]  act_ff, act_in;
   logic              valid_ff, valid_in;
   logic [RTT_W-1:0]  avg_ff, avg_in;
   logic [Q_W-1:0]    oq_ff, oq_in;
   logic [ACT_W-1:0]  oact_ff, oact_in;
   logic [CNT_W:0]    rem_sh;
   logic [CNT_W:0]    rem_diff;
   logic              ge;

   assign rem_sh   = {rem_ff, quot_ff[SUM_W-1]};
   assign rem_diff = rem_sh - {1'b0, div_ff};
   assign ge       = (rem_sh >= {1'b0, div_ff});

   assign rsp_tvalid   = valid_ff;
   assign rsp_mean_rtt = avg_ff;
   assign rsp_quality  = oq_ff;
   assign rsp_action   = oact_ff;

   always_comb begin
      state_in = state_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      step_in  = step_ff;
      qual_in  = qual_ff;
      act_in   = act_ff;
      avg_in   = avg_ff;
      oq_in    = oq_ff;
      oact_in  = oact_ff;
      q_pop    = 1'b0;
      valid_in = valid_ff && !rsp_tready;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               quot_in  = q_data[SUM_W-1:0];
               div_in   = q_data[SUM_W +: CNT_W];
               qual_in  = q_data[SUM_W+CNT_W +: Q_W];
               act_in   = q_data[SUM_W+CNT_W+Q_W +: ACT_W];
               rem_in   = '0;
               step_in  = '0;
               state_in = B_RUN;
            end
         end
         B_RUN: begin
            // one quotient bit per cycle, restoring
            rem_in  = ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            quot_in = {quot_ff[SUM_W-2:0], ge};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            // hold until the result register is free
            if (!valid_ff || rsp_tready) begin
               avg_in   = quot_ff[RTT_W-1:0];
               oq_in    = qual_ff;
               oact_in  = act_ff;
               valid_in = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      step_ff <= step_in;
      qual_ff <= qual_in;
      act_ff  <= act_in;
      avg_ff  <= avg_in;
      oq_ff   <= oq_in;
      oact_ff <= oact_in;
   end

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_RUN) |-> (div_ff != '0))
      else $error("divider running with zero count");

endmodule

// File: rtl/rtt_adaptive_quality_controller.sv
// Top level of the RTT-driven quality step controller.
// Each transfer on req carries one round-trip-time sample in ms and yields exactly one
// transfer on rsp with the floor of the window average, the quality after this sample
// and the action taken (0 none, 1 decreased, 2 increased). The front end takes a sample
// only after the last has passed accept, window-sum update, threshold products and decision
// (which waits while the queue is full) and passes it through a two-entry queue to the back
// end, whose restoring divider produces one quotient bit per cycle and takes a new item once
// its result is in the output register; the divider sets the sustained rate. While rsp stalls,
// the divider finishes its item and the front end fills the queue. Configuration is written
// through csr_wen/csr_index/csr_wdata while no sample is in flight, a rule for the user that
// the block does not enforce; writing initial_quality also loads the current quality. The
// sample ring has no clearing pass: an entry is only used once the window has filled past it.
module rtt_adaptive_quality_controller import raqc_pkg::*; #(
   parameter int WINDOW = WINDOW_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [RTT_W-1:0]      req_tdata,   // [15:0] rtt_ms
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [15:0] mean_rtt, [22:16] quality,
                                              // [24:23] action, [31:25] zero
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CNT_W   = $clog2(WINDOW + 1);
   localparam int ENTRY_W = RTT_W + 2 * CNT_W + Q_W + ACT_W;

   cfg_type            cfg_ff, cfg_in;
   logic [Q_W-1:0]     init_q_ff, init_q_in;
   logic               quality_load;
   logic               q_push;
   logic               q_pop;
   logic               q_full;
   logic               q_empty;
   logic [ENTRY_W-1:0] q_wr_data;
   logic [ENTRY_W-1:0] q_rd_data;
   logic [RTT_W-1:0]   avg;
   logic [Q_W-1:0]     quality;
   logic [ACT_W-1:0]   action;

   // Register writes: take the low bits of the write data for each register
   always_comb begin
      cfg_in       = cfg_ff;
      init_q_in    = init_q_ff;
      quality_load = 1'b0;
      if (csr_wen) begin
         unique case (csr_index)
            REG_STEP_DOWN:    cfg_in.step_down    = csr_wdata[Q_W-1:0];
            REG_STEP_UP:      cfg_in.step_up      = csr_wdata[Q_W-1:0];
            REG_QUALITY_MAX:  cfg_in.quality_max  = csr_wdata[Q_W-1:0];
            REG_QUALITY_MIN:  cfg_in.quality_min  = csr_wdata[Q_W-1:0];
            REG_HOLD_SAMPLES: cfg_in.hold_samples = csr_wdata[HOLD_W-1:0];
            REG_RTT_LOW:      cfg_in.rtt_low      = csr_wdata[RTT_W-1:0];
            REG_RTT_HIGH:     cfg_in.rtt_high     = csr_wdata[RTT_W-1:0];
            REG_INIT_QUALITY: begin
               init_q_in    = csr_wdata[Q_W-1:0];
               quality_load = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_down    <= RST_STEP_DOWN;
         cfg_ff.step_up      <= RST_STEP_UP;
         cfg_ff.quality_max  <= RST_QUALITY_MAX;
         cfg_ff.quality_min  <= RST_QUALITY_MIN;
         cfg_ff.hold_samples <= RST_HOLD_SAMPLES;
         cfg_ff.rtt_low      <= RST_RTT_LOW;
         cfg_ff.rtt_high     <= RST_RTT_HIGH;
         init_q_ff           <= RST_INIT_QUALITY;
      end else begin
         cfg_ff    <= cfg_in;
         init_q_ff <= init_q_in;
      end
   end

   raqc_front #(.WINDOW(WINDOW)) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .quality_load  (quality_load),
      .quality_value (init_q_in),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_rtt_ms    (req_tdata),
      .q_push        (q_push),
      .q_data        (q_wr_data),
      .q_full        (q_full)
   );

   raqc_queue #(.WIDTH(ENTRY_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rd_data),
      .empty     (q_empty)
   );

   raqc_back #(.WINDOW(WINDOW)) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .q_data          (q_rd_data),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_mean_rtt    (avg),
      .rsp_quality     (quality),
      .rsp_action      (action)
   );

   // Pack result fields, lowest field first, zero padded to whole bytes
   assign rsp_tdata = {(RSP_DATA_W - RTT_W - Q_W - ACT_W)'(0), action, quality, avg};

   a_action_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((action == ACT_NONE) || (action == ACT_DOWN) || (action == ACT_UP)))
      else $error("result carries an undefined action code");

   a_queue_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("front end pushed into a full queue");

endmodule

// File: sim/raqc_quality_checker.sv
// Result checker for the RTT quality controller: mirrors the registers, predicts each result.
module raqc_quality_checker import raqc_pkg::*; #(
   parameter int WINDOW = WINDOW_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [RTT_W-1:0]      req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatches,
   output int                    outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [RTT_W-1:0] mean_rtt;
      logic [Q_W-1:0]   quality;
      logic [ACT_W-1:0] action;
   } rtt_result_type;

   cfg_type          settings;
   logic [Q_W-1:0]   start_quality;
   logic [RTT_W-1:0] window_samples [WINDOW];
   int               slot_next;
   int               held_count;
   int               hold_count;
   int               quality_now;
   longint           window_sum;
   int               bad_count;
   rtt_result_type   expected_results [$];

   // Fold one sample into the window and apply the threshold step.
   function automatic rtt_result_type advance_controller(input logic [RTT_W-1:0] rtt);
      rtt_result_type r;
      int             prior_q;
      longint         high_lim;
      longint         low_lim;
      prior_q = quality_now;
      if (held_count < WINDOW) begin
         held_count++;
      end else begin
         window_sum -= longint'(window_samples[slot_next]);
      end
      window_sum += longint'(rtt);
      window_samples[slot_next] = rtt;
      slot_next = (slot_next + 1) % WINDOW;
      high_lim = longint'(settings.rtt_high) * held_count;
      low_lim  = longint'(settings.rtt_low) * held_count;
      if (hold_count >= int'(settings.hold_samples)) begin
         if (window_sum > high_lim) begin
            if (quality_now >= int'(settings.quality_min) + int'(settings.step_down))
               quality_now -= int'(settings.step_down);
            hold_count = 0;
         end else if (window_sum < low_lim) begin
            if (quality_now + int'(settings.step_up) <= int'(settings.quality_max))
               quality_now += int'(settings.step_up);
            hold_count = 0;
         end
      end
      if (hold_count < int'(HOLD_SAT)) hold_count++;
      r.mean_rtt = RTT_W'(window_sum / held_count);
      r.quality  = Q_W'(quality_now);
      if (quality_now < prior_q) begin
         r.action = ACT_DOWN;
      end else if (quality_now > prior_q) begin
         r.action = ACT_UP;
      end else begin
         r.action = ACT_NONE;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rtt_result_type got;
      rtt_result_type want;
      if (reset) begin
         settings = '{step_down: RST_STEP_DOWN, step_up: RST_STEP_UP,
                      quality_max: RST_QUALITY_MAX, quality_min: RST_QUALITY_MIN,
                      hold_samples: RST_HOLD_SAMPLES, rtt_low: RST_RTT_LOW,
                      rtt_high: RST_RTT_HIGH};
         start_quality = RST_INIT_QUALITY;
         quality_now   = int'(RST_INIT_QUALITY);
         slot_next     = 0;
         held_count    = 0;
         hold_count    = 0;
         window_sum    = 0;
         bad_count     = 0;
         expected_results.delete();
      end else begin
         if (csr_wen) begin
            case (csr_index)
               REG_STEP_DOWN:    settings.step_down    = csr_wdata[Q_W-1:0];
               REG_STEP_UP:      settings.step_up      = csr_wdata[Q_W-1:0];
               REG_QUALITY_MAX:  settings.quality_max  = csr_wdata[Q_W-1:0];
               REG_QUALITY_MIN:  settings.quality_min  = csr_wdata[Q_W-1:0];
               REG_HOLD_SAMPLES: settings.hold_samples = csr_wdata[HOLD_W-1:0];
               REG_RTT_LOW:      settings.rtt_low      = csr_wdata[RTT_W-1:0];
               REG_RTT_HIGH:     settings.rtt_high     = csr_wdata[RTT_W-1:0];
               REG_INIT_QUALITY: begin
                  start_quality = csr_wdata[Q_W-1:0];
                  quality_now   = int'(start_quality);
               end
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(advance_controller(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.mean_rtt = rsp_tdata[RTT_W-1:0];
            got.quality  = rsp_tdata[RTT_W +: Q_W];
            got.action   = rsp_tdata[RTT_W+Q_W +: ACT_W];
            if (expected_results.size() == 0) begin
               bad_count++;
               if (bad_count <= 10)
                  $display("%0t: result transfer with none pending: avg=%0d q=%0d act=%0d",
                           $time, got.mean_rtt, got.quality, got.action);
            end else begin
               want = expected_results.pop_front();
               if (got != want) begin
                  bad_count++;
                  if (bad_count <= 10)
                     $display("%0t: avg/q/act expected %0d/%0d/%0d, got %0d/%0d/%0d",
                              $time, want.mean_rtt, want.quality, want.action,
                              got.mean_rtt, got.quality, got.action);
               end
            end
         end
      end
      mismatches  <= bad_count;
      outstanding <= expected_results.size();
   end

endmodule

// File: sim/rtt_adaptive_quality_controller_tb.sv
// Testbench top of the RTT quality controller: stimulus, handshake pacing and verdict.
module rtt_adaptive_quality_controller_tb import raqc_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   // Even with both sides idling about half the time, ~1850 samples finish well below CYCLE_LIMIT.
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 64;
   localparam int NUM_SETTINGS = 9;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RTT_W-1:0]      req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wen    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = REG_STEP_DOWN;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int mismatches;
   int outstanding;
   int cycle_count   = 0;
   int send_idle_pct = 35;
   int recv_idle_pct = 54;

   // Thresholds in force, used to aim random samples around them
   cfg_type active_cfg;

   // Samples sent right after reset, on the reset register values:
   // six zeros reach the hold limit and raise the quality, then
   // saturated samples push the average over the high threshold.
   logic [RTT_W-1:0] reset_probe [10] = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                                          16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};

   // Samples for full-size steps with both thresholds at 100: the window first
   // drains the earlier extremes (one down step, then down steps pinned at the
   // bound), reaches an average exactly on the threshold (no step), goes just over
   // it (still pinned), then steps up by the whole range and down again.
   logic [RTT_W-1:0] step_probe [13] = '{16'd100, 16'd100, 16'd100, 16'd100, 16'd100,
                                         16'd100, 16'd100, 16'd100, 16'd100, 16'd100,
                                         16'd101, 16'd0, 16'hFFFF};

   int phase_items [NUM_SETTINGS] = '{190, 300, 190, 190, 190, 190, 190, 190, 190};

   rtt_adaptive_quality_controller #(
      .WINDOW(WINDOW_DEF)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   raqc_quality_checker #(
      .WINDOW(WINDOW_DEF)
   ) quality_chk (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .outstanding(outstanding)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Receiver: drop tready at random, at the rate of the current phase.
   always @(posedge clock) begin
      rsp_tready <= (int'($urandom_range(99)) >= recv_idle_pct);
   end

   // Watchdog: a hang or a lost result ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Drive one register; the caller lowers csr_wen after the last one.
   task automatic put_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Write the whole register set; initial_quality goes last so that it
   // also reloads the current quality.
   task automatic load_settings(input cfg_type c, input logic [Q_W-1:0] start_q);
      put_reg(REG_STEP_DOWN, CSR_DATA_W'(c.step_down));
      put_reg(REG_STEP_UP, CSR_DATA_W'(c.step_up));
      put_reg(REG_QUALITY_MAX, CSR_DATA_W'(c.quality_max));
      put_reg(REG_QUALITY_MIN, CSR_DATA_W'(c.quality_min));
      put_reg(REG_HOLD_SAMPLES, CSR_DATA_W'(c.hold_samples));
      put_reg(REG_RTT_LOW, c.rtt_low);
      put_reg(REG_RTT_HIGH, c.rtt_high);
      put_reg(REG_INIT_QUALITY, CSR_DATA_W'(start_q));
      csr_wen    <= 1'b0;
      active_cfg  = c;
   endtask

   // Present one sample, with a random gap first, and hold it until the
   // transfer. tvalid stays high when the next sample follows with no gap.
   task automatic send_sample(input logic [RTT_W-1:0] rtt);
      while (int'($urandom_range(99)) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rtt;
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop sending and wait until every pending result has come back.
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Pick a sample: below the low threshold, above the high one, close to
   // either, or anywhere in the field (extremes and single bits included).
   function automatic logic [RTT_W-1:0] pick_rtt(input int kind);
      int lo_t;
      int hi_t;
      int top_v;
      int bot_v;
      lo_t = int'(active_cfg.rtt_low);
      hi_t = int'(active_cfg.rtt_high);
      case (kind)
         0: return RTT_W'($urandom_range(lo_t));
         1: begin
            top_v = hi_t + hi_t / 2 + 64;
            if (top_v > 65535) top_v = 65535;
            return RTT_W'($urandom_range(top_v, hi_t));
         end
         2, 3: begin
            bot_v = (kind == 2) ? lo_t : hi_t;
            top_v = (bot_v + 16 > 65535) ? 65535 : bot_v + 16;
            bot_v = (bot_v < 16) ? 0 : bot_v - 16;
            return RTT_W'($urandom_range(top_v, bot_v));
         end
         default: begin
            case ($urandom_range(3))
               0: return RTT_W'($urandom);
               1: return ($urandom_range(1) == 0) ? 16'h0000 : 16'hFFFF;
               2: return RTT_W'(1) << $urandom_range(RTT_W - 1);
               default: return ~(RTT_W'(1) << $urandom_range(RTT_W - 1));
            endcase
         end
      endcase
   endfunction

   // Register set of each phase: reset values, the extremes (thresholds
   // that never fire, so the hold counter saturates; zero steps with both
   // thresholds firing; min above max), then random sets.
   task automatic pick_settings(input int phase, output cfg_type c,
                                output logic [Q_W-1:0] start_q);
      case (phase)
         0: begin
            c = '{step_down: RST_STEP_DOWN, step_up: RST_STEP_UP,
                  quality_max: RST_QUALITY_MAX, quality_min: RST_QUALITY_MIN,
                  hold_samples: RST_HOLD_SAMPLES, rtt_low: RST_RTT_LOW,
                  rtt_high: RST_RTT_HIGH};
            start_q = RST_INIT_QUALITY;
         end
         1: begin
            c = '{step_down: 7'd100, step_up: 7'd100, quality_max: 7'd100,
                  quality_min: 7'd0, hold_samples: 8'd0, rtt_low: 16'd0,
                  rtt_high: 16'hFFFF};
            start_q = 7'd100;
         end
         2: begin
            c = '{step_down: 7'd0, step_up: 7'd0, quality_max: 7'd100,
                  quality_min: 7'd0, hold_samples: 8'd255, rtt_low: 16'hFFFF,
                  rtt_high: 16'd0};
            start_q = 7'd0;
         end
         3: begin
            c = '{step_down: 7'd3, step_up: 7'd4, quality_max: 7'd40,
                  quality_min: 7'd60, hold_samples: 8'd1, rtt_low: 16'd500,
                  rtt_high: 16'd1000};
            start_q = 7'd100;
         end
         default: begin
            c.step_down   = Q_W'(($urandom_range(1) == 0) ? $urandom_range(20)
                                                          : $urandom_range(100));
            c.step_up     = Q_W'(($urandom_range(1) == 0) ? $urandom_range(20)
                                                          : $urandom_range(100));
            c.quality_min = Q_W'($urandom_range(40));
            c.quality_max = Q_W'($urandom_range(100, 50));
            if ($urandom_range(5) == 0) c.quality_max = Q_W'($urandom_range(40));
            c.hold_samples = HOLD_W'(($urandom_range(7) == 0) ? $urandom_range(255)
                                                              : $urandom_range(6));
            c.rtt_low  = RTT_W'($urandom_range(2000));
            c.rtt_high = RTT_W'(int'(c.rtt_low) + int'($urandom_range(3000)));
            if ($urandom_range(5) == 0) begin
               c.rtt_low  = RTT_W'($urandom);
               c.rtt_high = RTT_W'($urandom);
            end
            start_q = Q_W'($urandom_range(100));
         end
      endcase
   endtask

   initial begin
      cfg_type        c;
      logic [Q_W-1:0] start_q;
      int             burst_left;
      int             burst_kind;
      active_cfg = '{step_down: RST_STEP_DOWN, step_up: RST_STEP_UP,
                     quality_max: RST_QUALITY_MAX, quality_min: RST_QUALITY_MIN,
                     hold_samples: RST_HOLD_SAMPLES, rtt_low: RST_RTT_LOW,
                     rtt_high: RST_RTT_HIGH};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part, first on the reset register values
      foreach (reset_probe[i]) send_sample(reset_probe[i]);
      settle();
      c = '{step_down: 7'd100, step_up: 7'd100, quality_max: 7'd100, quality_min: 7'd0,
            hold_samples: 8'd0, rtt_low: 16'd100, rtt_high: 16'd100};
      load_settings(c, 7'd100);
      foreach (step_probe[i]) send_sample(step_probe[i]);
      settle();

      // Random part: runs of samples aimed at one side of the thresholds so
      // that the average really crosses them, mixed with short noisy runs.
      burst_left = 0;
      burst_kind = 0;
      for (int p = 0; p < NUM_SETTINGS; p++) begin
         case (p / 3)
            0: begin
               send_idle_pct = 35;
               recv_idle_pct = 54;
            end
            1: begin
               send_idle_pct = 54;
               recv_idle_pct = 35;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         pick_settings(p, c, start_q);
         load_settings(c, start_q);
         for (int n = 0; n < phase_items[p]; n++) begin
            if (burst_left == 0) begin
               burst_kind = $urandom_range(4);
               burst_left = $urandom_range(12, 1);
            end
            burst_left--;
            send_sample(pick_rtt(burst_kind));
         end
         settle();
      end

      // Let any stray result show up before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
